/* design/cads_pkg.sv */
// shared types, constants and constant tables for the arcade drive shaper
`default_nettype none

package cads_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int STREAM_W      = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_STICK_DB   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_DB    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_RISE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_FALL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA_G  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_SENS  = 3'd5;

	localparam logic [6:0]  RST_STICK_DB  = 7'd5;
	localparam logic [14:0] RST_MOVE_DB   = 15'd492;
	localparam logic [15:0] RST_SLEW_RISE = 16'd819;
	localparam logic [15:0] RST_SLEW_FALL = 16'd1638;
	localparam logic [15:0] RST_INERTIA_G = 16'd40960;
	localparam logic [15:0] RST_TURN_SENS = 16'd19661;

	typedef struct packed {
		logic [6:0]  stick_db;
		logic [14:0] move_db;
		logic [15:0] slew_rise;
		logic [15:0] slew_fall;
		logic [15:0] inertia_gain;
		logic [15:0] turn_sens;
	} cfg_t;

	// double-sine turn remap, kept in q30 so any fraction width can cut it
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] NL_Q30  = 64'd697932186;
	localparam logic [63:0] SIN_C0  = 64'd1686629713;
	localparam logic [63:0] SIN_C1  = 64'd693598667;
	localparam logic [63:0] SIN_C2  = 64'd85569305;
	localparam logic [63:0] SIN_C3  = 64'd5026995;
	localparam logic [63:0] SIN_C4  = 64'd172271;

	function automatic logic [63:0] sin_q30(input logic [63:0] u);
		logic [63:0] u2;
		logic [63:0] p;
		u2 = (u * u) >> 30;
		p = SIN_C4;
		p = SIN_C3 - ((p * u2) >> 30);
		p = SIN_C2 - ((p * u2) >> 30);
		p = SIN_C1 - ((p * u2) >> 30);
		p = SIN_C0 - ((p * u2) >> 30);
		return (p * u) >> 30;
	endfunction

	localparam logic [63:0] SIN_NL = sin_q30(NL_Q30);

	localparam int REMAP_DEPTH = 128;
	typedef logic [30:0] remap_rom_t [REMAP_DEPTH];

	function automatic remap_rom_t build_remap();
		remap_rom_t  t;
		logic [63:0] x;
		logic [63:0] f;
		logic [63:0] g;
		for (int m = 0; m < REMAP_DEPTH; m++) begin
			x = (64'(m) << 30) / 127;
			f = (sin_q30((NL_Q30 * x) >> 30) << 30) / SIN_NL;
			if (f > Q30_ONE)
				f = Q30_ONE;
			g = (sin_q30((NL_Q30 * f) >> 30) << 30) / SIN_NL;
			if (g > Q30_ONE)
				g = Q30_ONE;
			t[m] = g[30:0];
		end
		return t;
	endfunction

	localparam remap_rom_t REMAP_ROM = build_remap();

	// stick magnitude to fixed point, m * 2^fb / 127
	localparam int TOQ_W     = 21;
	localparam int TOQ_DEPTH = 129;
	typedef logic [TOQ_W-1:0] toq_tab_t [TOQ_DEPTH];

	function automatic toq_tab_t build_toq(input int fb);
		toq_tab_t    t;
		logic [63:0] v;
		for (int m = 0; m < TOQ_DEPTH; m++) begin
			v = (64'(m) << fb) / 127;
			t[m] = v[TOQ_W-1:0];
		end
		return t;
	endfunction

endpackage

`default_nettype wire

/* design/cheesy_arcade_drive_shaper.sv */
// arcade drive shaper top level: sequencer and datapath around one shared multiplier
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tdata: raw_throttle, raw_turn
//  m       | out | m_tvalid/m_tready  | m_tdata: forward_power, turn_power
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// an item steps through load, slew, gain, sum, addrs, mul1, mul2 and fin after acceptance
// (load, tip and fin in turn-in-place), the sequencer stepping up to three products
// through the one multiplier; s_tready is high only while the sequencer is idle,
// so a new item is taken only once the previous one is through
// the result sits in an output register; a stalled m side holds only the final step
// reset clears config to defaults and the throttle, turn and inertia history to zero
`default_nettype none

module cheesy_arcade_drive_shaper #(
	parameter int FRAC_BITS = cads_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [cads_pkg::STREAM_W-1:0]    s_tdata,   // raw_throttle[7:0], raw_turn[15:8]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [cads_pkg::STREAM_W-1:0]         m_tdata,   // forward_power[7:0], turn_power[15:8]
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cads_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cads_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int FB1 = FRAC_BITS + 1;
	localparam int QW  = FRAC_BITS + 2;
	localparam int QW1 = QW + 1;
	localparam int IW  = FRAC_BITS + 6;
	localparam int DW  = (FRAC_BITS + 9 > 25) ? FRAC_BITS + 9 : 25;
	localparam int MW  = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
	localparam int CW  = (FRAC_BITS + 1 > 15) ? FRAC_BITS + 1 : 15;
	localparam int SW  = (QW1 > 17) ? QW1 + 1 : 18;
	localparam int PW8 = FRAC_BITS + 8;

	localparam cads_pkg::toq_tab_t TOQ_TAB = cads_pkg::build_toq(FRAC_BITS);

	localparam logic signed [DW-1:0] ONE_D  = DW'(64'd1 << FRAC_BITS);
	localparam logic signed [DW-1:0] IMAX_D = DW'((64'd1 << (FRAC_BITS + 5)) - 64'd1);
	localparam logic [FB1-1:0]       HALF   = FB1'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_TIP, ST_SLEW, ST_GAIN, ST_SUM, ST_ADDRS, ST_MUL1, ST_MUL2, ST_FIN
	} state_t;

	state_t               state_q;
	cads_pkg::cfg_t       cfg;

	// history
	logic signed [QW-1:0] last_turn_q;
	logic signed [QW-1:0] last_thr_q;
	logic signed [IW-1:0] inertia_q;
	logic                 m_tvalid_q;
	logic [15:0]          m_tdata_q;

	// per-item working registers
	logic signed [7:0]    rt_q;
	logic signed [7:0]    rw_q;
	logic signed [QW-1:0] thr_q;
	logic signed [QW-1:0] trn_q;
	logic signed [QW-1:0] rm_q;
	logic [FB1-1:0]       rm_mag_q;
	logic                 tip_q;
	logic signed [QW-1:0] lin_q;
	logic signed [QW1-1:0] diff_q;
	logic signed [IW-1:0] sum_q;
	logic [FB1-1:0]       speed_q;
	logic signed [DW-1:0] rs_q;

	// load step
	logic [7:0]           rt_mag;
	logic [7:0]           rw_mag;
	logic [7:0]           rt_eff;
	logic [7:0]           rw_eff;
	logic [FB1-1:0]       thr_mag;
	logic [FB1-1:0]       trn_mag;
	logic [6:0]           remap_idx;
	logic [30:0]          remap_q30;
	logic [FB1-1:0]       rm_mag;
	logic                 tip;

	// slew step
	logic signed [SW-1:0] delta;
	logic signed [SW-1:0] rise_s;
	logic signed [SW-1:0] fall_s;
	logic signed [SW-1:0] lin_w;
	logic signed [QW-1:0] lin_mag_s;

	// sum step
	logic signed [DW-1:0] sum_w;
	logic signed [DW-1:0] sum_d;
	logic signed [DW-1:0] decayed;

	// shared multiplier
	logic                 mul_en;
	logic signed [DW-1:0] mul_a;
	logic [MW-1:0]        mul_b;
	logic signed [DW-1:0] prod;

	logic signed [DW-1:0] fwd_d;
	logic [7:0]           fwd_pwr;
	logic [7:0]           turn_pwr;
	logic                 out_free;

	cads_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cads_mul #(
		.FRAC_BITS (FRAC_BITS),
		.DW        (DW),
		.MW        (MW)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	function automatic logic [7:0] to_power(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] c;
		logic [FB1-1:0]       m;
		logic [PW8-1:0]       p;
		logic [6:0]           pw;
		c  = (v > ONE_D) ? ONE_D : ((v < -ONE_D) ? -ONE_D : v);
		m  = c[DW-1] ? FB1'(-c) : FB1'(c);
		p  = (PW8'(m) << 7) - PW8'(m);
		pw = p[FRAC_BITS +: 7];
		return c[DW-1] ? 8'(-{1'b0, pw}) : {1'b0, pw};
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// deadband, fixed-point scaling, remap and mode pick
	always_comb begin
		rt_mag    = rt_q[7] ? 8'(-rt_q) : 8'(rt_q);
		rw_mag    = rw_q[7] ? 8'(-rw_q) : 8'(rw_q);
		rt_eff    = (rt_mag < {1'b0, cfg.stick_db}) ? 8'd0 : rt_mag;
		rw_eff    = (rw_mag < {1'b0, cfg.stick_db}) ? 8'd0 : rw_mag;
		thr_mag   = FB1'(TOQ_TAB[rt_eff]);
		trn_mag   = FB1'(TOQ_TAB[rw_eff]);
		remap_idx = rw_eff[7] ? 7'd127 : rw_eff[6:0];
		remap_q30 = cads_pkg::REMAP_ROM[remap_idx];
		rm_mag    = remap_q30[30 -: FB1];
		tip       = (CW'(thr_mag) < CW'(cfg.move_db)) && (CW'(trn_mag) > CW'(cfg.move_db));
	end

	// throttle slew limit
	always_comb begin
		delta  = SW'(thr_q) - SW'(last_thr_q);
		rise_s = signed'(SW'(cfg.slew_rise));
		fall_s = signed'(SW'(cfg.slew_fall));
		if (delta > rise_s)
			lin_w = SW'(last_thr_q) + rise_s;
		else if (delta < -fall_s)
			lin_w = SW'(last_thr_q) - fall_s;
		else
			lin_w = SW'(thr_q);
		lin_mag_s = lin_q[QW-1] ? -lin_q : lin_q;
	end

	// inertia accumulate with saturation, then decay toward zero
	always_comb begin
		sum_w = DW'(inertia_q) + prod;
		if (sum_w > IMAX_D)
			sum_d = IMAX_D;
		else if (sum_w < -IMAX_D)
			sum_d = -IMAX_D;
		else
			sum_d = sum_w;
		if (DW'(sum_q) > ONE_D)
			decayed = DW'(sum_q) - ONE_D;
		else if (DW'(sum_q) < -ONE_D)
			decayed = DW'(sum_q) + ONE_D;
		else
			decayed = '0;
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_TIP: begin
				mul_en = 1'b1;
				mul_a  = DW'(rm_q);
				mul_b  = MW'(rm_mag_q);
			end
			ST_GAIN: begin
				mul_en = 1'b1;
				mul_a  = DW'(diff_q);
				mul_b  = MW'(cfg.inertia_gain);
			end
			ST_MUL1: begin
				mul_en = 1'b1;
				mul_a  = rs_q;
				mul_b  = MW'(speed_q);
			end
			ST_MUL2: begin
				mul_en = 1'b1;
				mul_a  = prod;
				mul_b  = MW'(cfg.turn_sens);
			end
			default: ;
		endcase
	end

	always_comb begin
		fwd_d    = tip_q ? '0 : DW'(lin_q);
		fwd_pwr  = to_power(fwd_d);
		turn_pwr = to_power(prod);
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					rt_q <= s_tdata[7:0];
					rw_q <= s_tdata[15:8];
				end
			end
			ST_LOAD: begin
				thr_q    <= rt_q[7] ? -signed'(QW'(thr_mag)) : signed'(QW'(thr_mag));
				trn_q    <= rw_q[7] ? -signed'(QW'(trn_mag)) : signed'(QW'(trn_mag));
				rm_q     <= (rw_q[7] && rw_eff != 8'd0) ?
				            -signed'(QW'(rm_mag)) : signed'(QW'(rm_mag));
				rm_mag_q <= rm_mag;
				tip_q    <= tip;
			end
			ST_SLEW: begin
				lin_q  <= QW'(lin_w);
				diff_q <= QW1'(trn_q) - QW1'(last_turn_q);
			end
			ST_SUM: begin
				sum_q   <= IW'(sum_d);
				speed_q <= (FB1'(lin_mag_s) < HALF) ? HALF : FB1'(lin_mag_s);
			end
			ST_ADDRS: begin
				rs_q <= DW'(rm_q) + DW'(sum_q);
			end
			default: ;
		endcase
	end

	// sequencer, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_turn_q <= '0;
			last_thr_q  <= '0;
			inertia_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// the final step sets valid itself when the old result leaves
			if (m_tvalid_q && m_tready && state_q != ST_FIN)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_LOAD;
				end
				ST_LOAD:  state_q <= tip ? ST_TIP : ST_SLEW;
				ST_TIP:   state_q <= ST_FIN;
				ST_SLEW:  state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_ADDRS;
				ST_ADDRS: begin
					inertia_q <= IW'(decayed);
					state_q   <= ST_MUL1;
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_FIN;
				ST_FIN: begin
					// wait here while the previous result is still unread
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						m_tdata_q   <= {turn_pwr, fwd_pwr};
						last_turn_q <= trn_q;
						last_thr_q  <= tip_q ? '0 : lin_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/cads_cfg_regs.sv */
// configuration register file written over the config port
`default_nettype none

module cads_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cads_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cads_pkg::CFG_DATA_W-1:0]   cfg_data,
	output cads_pkg::cfg_t                         cfg
);

	cads_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_db     <= cads_pkg::RST_STICK_DB;
			cfg_q.move_db      <= cads_pkg::RST_MOVE_DB;
			cfg_q.slew_rise    <= cads_pkg::RST_SLEW_RISE;
			cfg_q.slew_fall    <= cads_pkg::RST_SLEW_FALL;
			cfg_q.inertia_gain <= cads_pkg::RST_INERTIA_G;
			cfg_q.turn_sens    <= cads_pkg::RST_TURN_SENS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cads_pkg::REG_STICK_DB:  cfg_q.stick_db     <= cfg_data[6:0];
				cads_pkg::REG_MOVE_DB:   cfg_q.move_db      <= cfg_data[14:0];
				cads_pkg::REG_SLEW_RISE: cfg_q.slew_rise    <= cfg_data;
				cads_pkg::REG_SLEW_FALL: cfg_q.slew_fall    <= cfg_data;
				cads_pkg::REG_INERTIA_G: cfg_q.inertia_gain <= cfg_data;
				cads_pkg::REG_TURN_SENS: cfg_q.turn_sens    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/cads_mul.sv */
// shared signed-by-unsigned fixed-point multiplier with registered product
`default_nettype none

module cads_mul #(
	parameter int FRAC_BITS = cads_pkg::FRAC_BITS_DEF,
	parameter int DW        = 25,
	parameter int MW        = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [DW-1:0] a,
	input  wire logic [MW-1:0]        b,
	output logic signed [DW-1:0]      prod
);

	localparam int PW = DW + MW;

	logic [DW-1:0]        a_mag;
	logic [PW-1:0]        full;
	logic [DW-1:0]        r;
	logic signed [DW-1:0] prod_q;

	// magnitudes multiply, sign comes back after the truncating shift
	always_comb begin
		a_mag = a[DW-1] ? DW'(-a) : DW'(a);
		full  = PW'(a_mag) * PW'(b);
		r     = full[FRAC_BITS +: DW];
	end

	always_ff @(posedge clk) begin
		if (en)
			prod_q <= a[DW-1] ? signed'(-r) : signed'(r);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* design/cads_checker.sv */
// port-level checks for the arcade drive shaper, bound to the top level
`default_nettype none

module cads_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [cads_pkg::STREAM_W-1:0]  m_tdata
);

	// one item at a time: busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous item in work");

	// a result never shows up on the edge right after an item is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared too early");

	// powers stay within the symmetric range
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
		else $error("power out of range");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind cheesy_arcade_drive_shaper cads_checker u_cads_checker (.*);

`default_nettype wire
